// ===== design/ahrv_pkg.sv =====
// Shared constants, widths, codes and types of the audio history ring with voice activity detection.
package ahrv_pkg;

  // Ring depth and limits.
  localparam int HISTORY_DEPTH = 16000;
  localparam int MAX_WINDOW    = 512;
  localparam int MAX_BLOCK     = 1024;

  // Field widths fixed by the interface.
  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int START_W  = 27;
  localparam int WINMS_W  = 16;
  localparam int OFF_W    = 9;
  localparam int COUNT_W  = 10;
  localparam int TS_W     = 28;
  localparam int SHIFT_W  = 5;
  localparam int THR_W    = 15;
  localparam int ENERGY_W = 26;

  // Sixteen samples make one millisecond.
  localparam int MS_SHIFT = 4;

  // Derived widths.
  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int LEN_W  = $clog2(MAX_BLOCK + 1);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int OFFCMP_W = (WIN_W > OFF_W) ? WIN_W : OFF_W;
  localparam int LIM_W  = THR_W + 1 + LEN_W;
  localparam int ECMP_W = (LIM_W > ENERGY_W) ? LIM_W : ENERGY_W;

  // Modulo by the ring depth through a reciprocal multiply. With this scale
  // the quotient is exact for every 32-bit dividend.
  localparam int MOD_S  = WORD_W + ADDR_W;
  localparam int MOD_MW = WORD_W + 2;
  localparam logic [63:0] MOD_M =
    ((64'd1 << MOD_S) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam int MODP_W = WORD_W + MOD_MW;
  localparam int QUO_W  = WORD_W + 1 - ADDR_W;
  localparam int QD_W   = QUO_W + ADDR_W + 1;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

  // Configuration reset values.
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd16;
  localparam logic [THR_W-1:0]   THR_RST   = 15'd800;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam int PIPE_N     = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_SHIFT   = 1'b0,
    CFG_VAD_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_READ = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ready;
    logic [COUNT_W-1:0]         count;
    logic                       vad;
    logic [TS_W-1:0]            ts;
  } out_item_t;

endpackage

// ===== design/ahrv_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module ahrv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ===== design/audio_history_ring_with_vad_core.sv =====
// Top level of the audio history ring with block-energy voice activity detection.
//
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid_i / in_stall_o  kind, sample_word, block_end, origin_ms,
//                                               window_ms, offset
//  output    out        out_valid_o / out_stall_i sample_out, ready_res, window_count,
//                                               vad_active, timestamp_ms
//  config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item is taken every cycle while the input does not stall. Each item runs through a
// five-stage pipeline and its result is pushed into an eight-entry queue.
// The single ring RAM port is used by every item in the same stage and in input
// order, so writes and window reads never overtake each other.
// Reset takes effect at once; no clearing pass runs, since a window read only
// returns RAM data for samples that have been written since reset.
// The input stalls only when the queue plus the pipeline hold eight results,
// which happens only when the output side has stalled.
module audio_history_ring_with_vad_core
  import ahrv_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic signed [WORD_W-1:0]   sample_word_i,
  input  logic                       block_end_i,
  input  logic [START_W-1:0]         origin_ms_i,
  input  logic [WINMS_W-1:0]         window_ms_i,
  input  logic [OFF_W-1:0]           offset_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       ready_res_o,
  output logic [COUNT_W-1:0]         window_count_o,
  output logic                       vad_active_o,
  output logic [TS_W-1:0]            timestamp_ms_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [SHIFT_W-1:0] shift_q;
  logic [THR_W-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RST;
      thr_q   <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INPUT_SHIFT:   shift_q <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_VAD_THRESHOLD: thr_q   <= cfg_wdata_i[THR_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes and occupancy. occ_q counts every item accepted whose result has
  // not yet been transferred, so the queue can never overflow.
  // ---------------------------------------------------------------------------
  logic                 in_acc;
  logic                 out_acc;
  logic [OCC_W-1:0]     occ_q;
  logic [OCC_W-1:0]     fcnt_q;
  logic [PIPE_N-1:0]    pipe_vld_q;

  assign in_stall_o = (occ_q == OCC_W'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (fcnt_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= '0;
    end else begin
      pipe_vld_q <= {pipe_vld_q[PIPE_N-2:0], in_acc};
    end
  end

  // ---------------------------------------------------------------------------
  // Counters that advance at the input transfer of a sample word: total samples, ring
  // write position and block length. The block close decision is made here too.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] sw_q;
  logic [WORD_W-1:0] sw_inc;
  logic [ADDR_W-1:0] wp_q;
  logic [LEN_W-1:0]  blen_q;
  logic [LEN_W-1:0]  blen_inc;
  logic              close_now;
  logic              is_word;

  assign is_word   = (item_kind_e'(kind_i) == KIND_WORD);
  assign sw_inc    = sw_q + WORD_W'(1);
  assign blen_inc  = blen_q + LEN_W'(1);
  assign close_now = block_end_i || (blen_inc >= LEN_W'(MAX_BLOCK));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= '0;
      wp_q   <= '0;
      blen_q <= '0;
    end else if (in_acc && is_word) begin
      sw_q   <= sw_inc;
      wp_q   <= (wp_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
      blen_q <= close_now ? '0 : blen_inc;
    end
  end

  // Stage 1: captured input and counter snapshots.
  logic                     s1_kind;
  logic signed [WORD_W-1:0] s1_word;
  logic [START_W-1:0]       s1_start;
  logic [WINMS_W-1:0]       s1_win;
  logic [OFF_W-1:0]         s1_off;
  logic [WORD_W-1:0]        s1_sw;
  logic [ADDR_W-1:0]        s1_wp;
  logic                     s1_close;
  logic [LEN_W-1:0]         s1_len;
  logic [TS_W-1:0]          s1_ts;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind  <= kind_i;
      s1_word  <= sample_word_i;
      s1_start <= origin_ms_i;
      s1_win   <= window_ms_i;
      s1_off   <= offset_i;
      s1_sw    <= sw_q;
      s1_wp    <= wp_q;
      s1_close <= is_word && close_now;
      s1_len   <= blen_inc;
      s1_ts    <= sw_inc[MS_SHIFT +: TS_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 logic: shift and saturate the word; for a window read, the window
  // size, the ready test and the linear sample index.
  // ---------------------------------------------------------------------------
  logic signed [WORD_W-1:0] shifted;
  logic                     fits;
  logic [SAMPLE_W-1:0]      sat_val;
  logic [SAMPLE_W-1:0]      mag;
  logic [WINMS_W+MS_SHIFT-1:0] win16;
  logic [WIN_W-1:0]         want;
  logic [START_W+MS_SHIFT-1:0] start16;
  logic                     rd_ready;
  logic                     rd_hit;
  logic [WORD_W-1:0]        lin_idx;
  logic                     s1_read;

  always_comb begin
    s1_read = (item_kind_e'(s1_kind) == KIND_READ);
    shifted = s1_word >>> shift_q;
    fits    = (&shifted[WORD_W-1:SAMPLE_W-1]) || !(|shifted[WORD_W-1:SAMPLE_W-1]);
    if (fits) begin
      sat_val = shifted[SAMPLE_W-1:0];
    end else begin
      sat_val = shifted[WORD_W-1] ? SAT_NEG : SAT_POS;
    end
    mag = sat_val[SAMPLE_W-1] ? (~sat_val + SAMPLE_W'(1)) : sat_val;

    win16 = {s1_win, {MS_SHIFT{1'b0}}};
    if (win16 > (WINMS_W + MS_SHIFT)'(MAX_WINDOW)) begin
      want = WIN_W'(MAX_WINDOW);
    end else begin
      want = win16[WIN_W-1:0];
    end
    start16  = {s1_start, {MS_SHIFT{1'b0}}};
    rd_ready = ({1'b0, s1_sw} >= ((WORD_W + 1)'(start16) + (WORD_W + 1)'(want)));
    rd_hit   = rd_ready && (OFFCMP_W'(s1_off) < OFFCMP_W'(want));
    lin_idx  = WORD_W'(start16) + WORD_W'(s1_off);
  end

  // Stage 2 registers.
  logic                kind2;
  logic                s2_close;
  logic [LEN_W-1:0]    s2_len;
  logic [TS_W-1:0]     s2_ts;
  logic [ADDR_W-1:0]   s2_wp;
  logic [SAMPLE_W-1:0] s2_sat;
  logic [SAMPLE_W-1:0] s2_mag;
  logic [WORD_W-1:0]   s2_x;
  logic                s2_ready;
  logic                s2_hit;
  logic [WIN_W-1:0]    s2_want;

  always_ff @(posedge clk_i) begin
    kind2    <= s1_kind;
    s2_close <= s1_close;
    s2_len   <= s1_len;
    s2_ts    <= s1_ts;
    s2_wp    <= s1_wp;
    s2_sat   <= sat_val;
    s2_mag   <= mag;
    s2_x     <= lin_idx;
    s2_ready <= s1_read && rd_ready;
    s2_hit   <= s1_read && rd_hit;
    s2_want  <= s1_read ? want : '0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2 logic: saturating energy accumulation and the reciprocal multiply
  // that gives the quotient of the sample index by the ring depth.
  // ---------------------------------------------------------------------------
  logic [ENERGY_W-1:0] e_acc_q;
  logic [ENERGY_W:0]   e_sum;
  logic [ENERGY_W-1:0] e_sat;
  logic                s2_word;
  logic [MODP_W-1:0]   mod_prod;

  always_comb begin
    s2_word  = pipe_vld_q[1] && (item_kind_e'(kind2) == KIND_WORD);
    e_sum    = {1'b0, e_acc_q} + (ENERGY_W + 1)'(s2_mag);
    e_sat    = e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];
    mod_prod = MODP_W'(s2_x) * MODP_W'(MOD_M[MOD_MW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_acc_q <= '0;
    end else if (s2_word) begin
      e_acc_q <= s2_close ? '0 : e_sat;
    end
  end

  // Stage 3 registers.
  logic                kind3;
  logic                s3_close;
  logic [LEN_W-1:0]    s3_len;
  logic [TS_W-1:0]     s3_ts;
  logic [ADDR_W-1:0]   s3_wp;
  logic [SAMPLE_W-1:0] s3_sat;
  logic [WORD_W-1:0]   s3_x;
  logic [QUO_W-1:0]    s3_q;
  logic [ENERGY_W-1:0] s3_energy;
  logic                s3_ready;
  logic                s3_hit;
  logic [WIN_W-1:0]    s3_want;

  always_ff @(posedge clk_i) begin
    kind3     <= kind2;
    s3_close  <= s2_close;
    s3_len    <= s2_len;
    s3_ts     <= s2_ts;
    s3_wp     <= s2_wp;
    s3_sat    <= s2_sat;
    s3_x      <= s2_x;
    s3_q      <= mod_prod[MOD_S +: QUO_W];
    s3_energy <= e_sat;
    s3_ready  <= s2_ready;
    s3_hit    <= s2_hit;
    s3_want   <= s2_want;
  end

  // ---------------------------------------------------------------------------
  // Stage 3 logic: quotient times depth, and the activity limit. The mean
  // exceeds the threshold exactly when energy >= (threshold + 1) * length.
  // ---------------------------------------------------------------------------
  logic [QD_W-1:0]    qd_prod;
  logic [LIM_W-1:0]   lim_prod;
  logic [THR_W:0]     thr_inc;

  always_comb begin
    qd_prod  = QD_W'(s3_q) * QD_W'(HISTORY_DEPTH);
    thr_inc  = {1'b0, thr_q} + (THR_W + 1)'(1);
    lim_prod = LIM_W'(thr_inc) * LIM_W'(s3_len);
  end

  // Stage 4 registers.
  logic                kind4;
  logic                s4_close;
  logic [TS_W-1:0]     s4_ts;
  logic [ADDR_W-1:0]   s4_wp;
  logic [SAMPLE_W-1:0] s4_sat;
  logic [WORD_W-1:0]   s4_x;
  logic [WORD_W-1:0]   s4_qd;
  logic [ENERGY_W-1:0] s4_energy;
  logic [LIM_W-1:0]    s4_lim;
  logic                s4_ready;
  logic                s4_hit;
  logic [WIN_W-1:0]    s4_want;

  always_ff @(posedge clk_i) begin
    kind4     <= kind3;
    s4_close  <= s3_close;
    s4_ts     <= s3_ts;
    s4_wp     <= s3_wp;
    s4_sat    <= s3_sat;
    s4_x      <= s3_x;
    s4_qd     <= qd_prod[WORD_W-1:0];
    s4_energy <= s3_energy;
    s4_lim    <= lim_prod;
    s4_ready  <= s3_ready;
    s4_hit    <= s3_hit;
    s4_want   <= s3_want;
  end

  // ---------------------------------------------------------------------------
  // Stage 4 logic: ring access and block close. Every item uses the RAM port
  // here in input order: a word writes its sample, a window read reads.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]   s4_r;
  logic                s4_word;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                vad_q;
  logic                vad_d;
  logic [TS_W-1:0]     ts_q;
  logic [TS_W-1:0]     ts_d;

  always_comb begin
    s4_r     = s4_x - s4_qd;
    s4_word  = (item_kind_e'(kind4) == KIND_WORD);
    ram_we   = pipe_vld_q[3] && s4_word;
    ram_addr = s4_word ? s4_wp : s4_r[ADDR_W-1:0];
    vad_d    = vad_q;
    ts_d     = ts_q;
    if (pipe_vld_q[3] && s4_close) begin
      vad_d = (ECMP_W'(s4_energy) >= ECMP_W'(s4_lim));
      ts_d  = s4_ts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vad_q <= 1'b0;
      ts_q  <= '0;
    end else begin
      vad_q <= vad_d;
      ts_q  <= ts_d;
    end
  end

  ahrv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (pipe_vld_q[3]),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s4_sat),
    .rdata_o (ram_rdata)
  );

  // Stage 5 registers; the RAM read data arrives alongside them.
  logic             s5_ready;
  logic             s5_hit;
  logic [WIN_W-1:0] s5_want;
  logic             s5_vad;
  logic [TS_W-1:0]  s5_ts;

  always_ff @(posedge clk_i) begin
    s5_ready <= s4_ready;
    s5_hit   <= s4_hit;
    s5_want  <= s4_want;
    s5_vad   <= vad_d;
    s5_ts    <= ts_d;
  end

  // ---------------------------------------------------------------------------
  // Result queue.
  // ---------------------------------------------------------------------------
  out_item_t          res_item;
  out_item_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wptr_q;
  logic [FIFO_PW-1:0] rptr_q;
  logic               push;

  assign push = pipe_vld_q[4];

  always_comb begin
    res_item.sample = s5_hit ? ram_rdata : '0;
    res_item.ready  = s5_ready;
    res_item.count  = COUNT_W'(s5_want);
    res_item.vad    = s5_vad;
    res_item.ts     = s5_ts;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= res_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fcnt_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + FIFO_PW'(1);
      end
      if (out_acc) begin
        rptr_q <= rptr_q + FIFO_PW'(1);
      end
      fcnt_q <= fcnt_q + OCC_W'(push) - OCC_W'(out_acc);
    end
  end

  assign sample_out_o   = fifo_q[rptr_q].sample;
  assign ready_res_o    = fifo_q[rptr_q].ready;
  assign window_count_o = fifo_q[rptr_q].count;
  assign vad_active_o   = fifo_q[rptr_q].vad;
  assign timestamp_ms_o = fifo_q[rptr_q].ts;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_occ_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OCC_W'($countones(pipe_vld_q)) + fcnt_q)
    else $error("occupancy differs from items in flight plus queued results");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fcnt_q != OCC_W'(FIFO_DEPTH)) || out_acc)
    else $error("result pushed into a full queue");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(FIFO_DEPTH))
    else $error("more items in flight than the queue can hold");

  a_blen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blen_q < LEN_W'(MAX_BLOCK))
    else $error("block length reached its limit without a close");

  a_rd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_vld_q[3] && !s4_word) |-> (s4_r < WORD_W'(HISTORY_DEPTH)))
    else $error("ring read index not reduced below the ring depth");

endmodule
